/* design/avcsps_pkg.sv */
// avcsps_pkg: types and phase codes for the sps header parser
// no dependencies
package avcsps_pkg;
	localparam int PhW = 6;
	localparam logic [PhW-1:0] PH_SKIP = 6'd0, PH_PROFILE = 6'd1, PH_CONSTR = 6'd2,
		PH_LEVEL = 6'd3, PH_SPSID = 6'd4, PH_CHROMA = 6'd5, PH_SEPCOL = 6'd6,
		PH_DEPTHL = 6'd7, PH_DEPTHC = 6'd8, PH_BYPASS = 6'd9, PH_SCALPRES = 6'd10,
		PH_SCALFLAGS = 6'd11, PH_FRAMENUM = 6'd12, PH_POCTYPE = 6'd13,
		PH_POCLSB = 6'd14, PH_DELTAZERO = 6'd15, PH_OFFNONREF = 6'd16,
		PH_OFFTB = 6'd17, PH_CYCLECNT = 6'd18, PH_CYCLEOFF = 6'd19,
		PH_MAXREF = 6'd20, PH_GAPS = 6'd21, PH_WIDTH = 6'd22, PH_HEIGHT = 6'd23,
		PH_FRAMEONLY = 6'd24, PH_MBAFF = 6'd25, PH_DIRECT = 6'd26,
		PH_CROPFLAG = 6'd27, PH_CROPL = 6'd28, PH_CROPR = 6'd29, PH_CROPT = 6'd30,
		PH_CROPB = 6'd31, PH_DONE = 6'd32;
	localparam logic [1:0] ST_OK = 2'd0, ST_TRUNC = 2'd1, ST_SCAL = 2'd2, ST_RANGE = 2'd3;
	localparam logic [3:0] SKIP_RESET = 4'd5;
	// dimension limit, sized to the 17/18 bit width and height accumulators
	localparam int DIM_BITS = 16;

	typedef struct packed {
		logic [7:0]  profile;
		logic [7:0]  level;
		logic [15:0] frame_width;
		logic [15:0] frame_height;
		logic [1:0]  status;
	} res_t;

	function automatic logic high_profile(input logic [7:0] p);
		return p == 8'd100 || p == 8'd110 || p == 8'd122 || p == 8'd244 ||
			p == 8'd44 || p == 8'd83 || p == 8'd86 || p == 8'd118;
	endfunction
endpackage

/* design/avcsps_if.sv */
// avcsps_in_if / avcsps_out_if: valid/ready channels of the sps parser
// depends on avcsps_pkg
interface avcsps_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;
	modport source (output valid, data_byte, last_byte, input ready);
	modport sink (input valid, data_byte, last_byte, output ready);
endinterface

interface avcsps_out_if import avcsps_pkg::*; ;
	logic valid;
	logic ready;
	res_t res;
	modport source (output valid, res, input ready);
	modport sink (input valid, res, output ready);
endinterface

/* design/avcsps_bitstep.sv */
// avcsps_bitstep: one bit of the sps field parser
// depends on avcsps_pkg
module avcsps_bitstep import avcsps_pkg::*; #(
	parameter int MAX_GOLOMB_ZEROS = 31
) (
	input  logic [PhW-1:0] ph_i,
	input  logic [4:0]     fbc_i,
	input  logic [5:0]     gz_i,
	input  logic [31:0]    gv_i,
	input  logic [7:0]     prof_i,
	input  logic [7:0]     lev_i,
	input  logic [1:0]     chroma_i,
	input  logic [7:0]     cyc_i,
	input  logic           fonly_i,
	input  logic [16:0]    w_i,
	input  logic [17:0]    h_i,
	input  logic [1:0]     err_i,
	input  logic           b,
	output logic [PhW-1:0] ph_o,
	output logic [4:0]     fbc_o,
	output logic [5:0]     gz_o,
	output logic [31:0]    gv_o,
	output logic [7:0]     prof_o,
	output logic [7:0]     lev_o,
	output logic [1:0]     chroma_o,
	output logic [7:0]     cyc_o,
	output logic           fonly_o,
	output logic [16:0]    w_o,
	output logic [17:0]    h_o,
	output logic [1:0]     err_o,
	output logic           emit_o,
	output logic [1:0]     est_o,
	output logic           edims_o
);
	localparam logic [17:0] DimMax = 18'((64'd1 << DIM_BITS) - 64'd1);
	localparam logic [32:0] DimMax16 = 33'(DimMax >> 4);
	logic [PhW-1:0] nph;
	logic           gogo, ue_fin, failr;
	logic [31:0]    v, gvs;
	logic           cxs;
	logic [1:0]     cys;
	logic [33:0]    dsub;
	logic [17:0]    acc;

	always_comb begin
		ph_o = ph_i; fbc_o = fbc_i; gz_o = gz_i; gv_o = gv_i; prof_o = prof_i;
		lev_o = lev_i; chroma_o = chroma_i; cyc_o = cyc_i; fonly_o = fonly_i;
		w_o = w_i; h_o = h_i; err_o = err_i; emit_o = 1'b0; est_o = err_i;
		edims_o = 1'b1; nph = ph_i; gogo = 1'b0; ue_fin = 1'b0; failr = 1'b0;
		v = '0;
		// crop units are 1, 2 or 4, taken as shift amounts
		cxs = (chroma_i == 2'd1 || chroma_i == 2'd2);
		cys = ((chroma_i == 2'd1) ? 2'd1 : 2'd0) + (fonly_i ? 2'd0 : 2'd1);
		gvs = {gv_i[30:0], b};
		acc = (ph_i == PH_CROPL || ph_i == PH_CROPR) ? {1'b0, w_i} : h_i;
		dsub = '0;
		case (ph_i)
			PH_SKIP, PH_DONE: ;
			PH_PROFILE: begin
				prof_o = {prof_i[6:0], b}; fbc_o = fbc_i + 5'd1;
				if (fbc_i == 5'd7) begin nph = PH_CONSTR; gogo = 1'b1; end
			end
			PH_CONSTR: begin
				fbc_o = fbc_i + 5'd1;
				if (fbc_i == 5'd7) begin nph = PH_LEVEL; gogo = 1'b1; end
			end
			PH_LEVEL: begin
				lev_o = {lev_i[6:0], b}; fbc_o = fbc_i + 5'd1;
				if (fbc_i == 5'd7) begin nph = PH_SPSID; gogo = 1'b1; end
			end
			PH_SEPCOL: begin nph = PH_DEPTHL; gogo = 1'b1; end
			PH_BYPASS: begin nph = PH_SCALPRES; gogo = 1'b1; end
			PH_SCALPRES: begin nph = b ? PH_SCALFLAGS : PH_FRAMENUM; gogo = 1'b1; end
			PH_SCALFLAGS: begin
				if (b && err_i == ST_OK) err_o = ST_SCAL;
				fbc_o = fbc_i + 5'd1;
				if (fbc_o == ((chroma_i == 2'd3) ? 5'd12 : 5'd8)) begin
					nph = PH_FRAMENUM; gogo = 1'b1;
				end
			end
			PH_DELTAZERO: begin nph = PH_OFFNONREF; gogo = 1'b1; end
			PH_GAPS: begin nph = PH_WIDTH; gogo = 1'b1; end
			PH_FRAMEONLY: begin
				fonly_o = b;
				if (!b && h_i > (DimMax >> 1)) failr = 1'b1;
				else begin
					if (!b) h_o = {h_i[16:0], 1'b0};
					nph = b ? PH_DIRECT : PH_MBAFF; gogo = 1'b1;
				end
			end
			PH_MBAFF: begin nph = PH_DIRECT; gogo = 1'b1; end
			PH_DIRECT: begin nph = PH_CROPFLAG; gogo = 1'b1; end
			PH_CROPFLAG: begin
				if (b) begin nph = PH_CROPL; gogo = 1'b1; end
				else emit_o = 1'b1;
			end
			default: begin
				// ue(v) exp-golomb decode
				if (gv_i == '0) begin
					if (!b) begin
						if (gz_i >= 6'(MAX_GOLOMB_ZEROS)) failr = 1'b1;
						else gz_o = gz_i + 6'd1;
					end else if (gz_i == '0) begin
						ue_fin = 1'b1; v = '0;
					end else gv_o = 32'd1;
				end else begin
					gv_o = gvs; gz_o = gz_i - 6'd1;
					if (gz_i == 6'd1) begin
						ue_fin = 1'b1; v = gvs - 32'd1; gv_o = '0;
					end
				end
			end
		endcase
		if (ue_fin) begin
			gogo = 1'b1;
			case (ph_i)
				PH_SPSID: begin
					if (high_profile(prof_i)) nph = PH_CHROMA;
					else begin
						chroma_o = (prof_i == 8'd183) ? 2'd0 : 2'd1;
						nph = PH_FRAMENUM;
					end
				end
				PH_CHROMA: begin
					if (v > 32'd3) begin failr = 1'b1; gogo = 1'b0; end
					else begin
						chroma_o = v[1:0];
						nph = (v == 32'd3) ? PH_SEPCOL : PH_DEPTHL;
					end
				end
				PH_DEPTHL: nph = PH_DEPTHC;
				PH_DEPTHC: nph = PH_BYPASS;
				PH_FRAMENUM: nph = PH_POCTYPE;
				PH_POCTYPE: nph = (v == 32'd0) ? PH_POCLSB :
					((v == 32'd1) ? PH_DELTAZERO : PH_MAXREF);
				PH_POCLSB: nph = PH_MAXREF;
				PH_OFFNONREF: nph = PH_OFFTB;
				PH_OFFTB: nph = PH_CYCLECNT;
				PH_CYCLECNT: begin
					if (v > 32'd255) begin failr = 1'b1; gogo = 1'b0; end
					else begin
						cyc_o = v[7:0];
						nph = (v == 32'd0) ? PH_MAXREF : PH_CYCLEOFF;
					end
				end
				PH_CYCLEOFF: begin
					cyc_o = cyc_i - 8'd1;
					nph = (cyc_o == 8'd0) ? PH_MAXREF : PH_CYCLEOFF;
				end
				PH_MAXREF: nph = PH_GAPS;
				PH_WIDTH, PH_HEIGHT: begin
					if ({1'b0, v} + 33'd1 > DimMax16) begin failr = 1'b1; gogo = 1'b0; end
					else if (ph_i == PH_WIDTH) begin
						w_o = 17'({v[15:0] + 16'd1, 4'd0}); nph = PH_HEIGHT;
					end else begin
						h_o = 18'({v[15:0] + 16'd1, 4'd0}); nph = PH_FRAMEONLY;
					end
				end
				PH_CROPL, PH_CROPR, PH_CROPT, PH_CROPB: begin
					dsub = (ph_i == PH_CROPL || ph_i == PH_CROPR) ?
						({2'b0, v} << cxs) : ({2'b0, v} << cys);
					if (dsub > {16'b0, acc}) begin failr = 1'b1; gogo = 1'b0; end
					else begin
						if (ph_i == PH_CROPL || ph_i == PH_CROPR) w_o = w_i - dsub[16:0];
						else h_o = h_i - dsub[17:0];
						if (ph_i == PH_CROPB) begin emit_o = 1'b1; gogo = 1'b0; end
						else nph = ph_i + 6'd1;
					end
				end
				default: nph = PH_DONE;
			endcase
		end
		if (gogo) begin ph_o = nph; fbc_o = '0; gz_o = '0; gv_o = '0; end
		if (failr) begin
			err_o = ST_RANGE; emit_o = 1'b1; est_o = ST_RANGE; edims_o = 1'b0;
		end else est_o = err_o;
		if (emit_o) ph_o = PH_DONE;
	end
endmodule

/* design/avc_sps_header_parser_top.sv */
// avc_sps_header_parser_top: one sps byte per cycle while the output is not stalled, eight bit steps unrolled
// depends on avcsps_pkg, avcsps_if, avcsps_bitstep
// result: registered, valid in the cycle after the byte that causes it is taken
// throughput: one byte per cycle unless a waiting result stalls the input; eight chained bit steps set the path
// single output register: input stalls while a result waits and the sink is not ready
// reset: asynchronous arst_n clears parse state, skip_q back to 5
module avc_sps_header_parser_top import avcsps_pkg::*; #(
	parameter int MAX_GOLOMB_ZEROS = 31
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [3:0] cfg_wdata,
	avcsps_in_if.sink    in_ch,
	avcsps_out_if.source out_ch
);
	logic [3:0] skip_q, skc_q;
	logic [PhW-1:0] ph_q;
	logic [4:0] fbc_q; logic [5:0] gz_q; logic [31:0] gv_q;
	logic [7:0] prof_q, lev_q, cyc_q; logic [1:0] chroma_q, err_q;
	logic fonly_q, emitted_q; logic [16:0] w_q; logic [17:0] h_q;
	logic ov_q; res_t res_q;

	logic [PhW-1:0] ph [9]; logic [4:0] fbc [9]; logic [5:0] gz [9];
	logic [31:0] gv [9]; logic [7:0] prof [9], lev [9], cyc [9];
	logic [1:0] chroma [9], err [9]; logic fonly [9]; logic [16:0] w [9];
	logic [17:0] h [9]; logic em [8]; logic [1:0] est [8]; logic ed [8];

	logic take, hit, emit_any, r_emit; res_t r_n;

	assign in_ch.ready = !ov_q || out_ch.ready;
	assign take = in_ch.valid && in_ch.ready;
	assign out_ch.valid = ov_q;
	assign out_ch.res = res_q;

	always_comb begin
		ph[0] = ph_q; fbc[0] = fbc_q; gz[0] = gz_q; gv[0] = gv_q;
		prof[0] = prof_q; lev[0] = lev_q; cyc[0] = cyc_q; chroma[0] = chroma_q;
		err[0] = err_q; fonly[0] = fonly_q; w[0] = w_q; h[0] = h_q;
		if (ph_q == PH_SKIP && skc_q >= skip_q) begin
			ph[0] = PH_PROFILE; fbc[0] = '0; gz[0] = '0; gv[0] = '0;
		end
	end

	for (genvar i = 0; i < 8; i++) begin : g_bit
		avcsps_bitstep #(.MAX_GOLOMB_ZEROS(MAX_GOLOMB_ZEROS)) u_bit (
			.ph_i(ph[i]), .fbc_i(fbc[i]), .gz_i(gz[i]), .gv_i(gv[i]),
			.prof_i(prof[i]), .lev_i(lev[i]), .chroma_i(chroma[i]), .cyc_i(cyc[i]),
			.fonly_i(fonly[i]), .w_i(w[i]), .h_i(h[i]), .err_i(err[i]),
			.b(in_ch.data_byte[7-i]),
			.ph_o(ph[i+1]), .fbc_o(fbc[i+1]), .gz_o(gz[i+1]), .gv_o(gv[i+1]),
			.prof_o(prof[i+1]), .lev_o(lev[i+1]), .chroma_o(chroma[i+1]),
			.cyc_o(cyc[i+1]), .fonly_o(fonly[i+1]), .w_o(w[i+1]), .h_o(h[i+1]),
			.err_o(err[i+1]), .emit_o(em[i]), .est_o(est[i]), .edims_o(ed[i])
		);
	end

	always_comb begin
		hit = 1'b0; r_n = '0;
		for (int i = 0; i < 8; i++) begin
			if (em[i] && !hit) begin
				hit = 1'b1;
				r_n.profile = prof[i+1]; r_n.level = lev[i+1]; r_n.status = est[i];
				r_n.frame_width = ed[i] ? w[i+1][15:0] : '0;
				r_n.frame_height = ed[i] ? h[i+1][15:0] : '0;
			end
		end
		emit_any = hit;
		if (!hit && in_ch.last_byte && !emitted_q) begin
			emit_any = 1'b1;
			r_n = '0; r_n.profile = prof[8]; r_n.level = lev[8]; r_n.status = ST_TRUNC;
		end
		r_emit = emit_any;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			skip_q <= SKIP_RESET; ph_q <= PH_SKIP; skc_q <= '0; fbc_q <= '0;
			gz_q <= '0; gv_q <= '0; prof_q <= '0; lev_q <= '0; chroma_q <= 2'd1;
			cyc_q <= '0; fonly_q <= 1'b0; w_q <= '0; h_q <= '0; err_q <= '0;
			emitted_q <= 1'b0; ov_q <= 1'b0;
		end else begin
			if (cfg_we) skip_q <= cfg_wdata;
			if (take && r_emit) ov_q <= 1'b1;
			else if (out_ch.ready) ov_q <= 1'b0;
			if (take) begin
				if (in_ch.last_byte) begin
					ph_q <= PH_SKIP; skc_q <= '0; fbc_q <= '0; gz_q <= '0; gv_q <= '0;
					prof_q <= '0; lev_q <= '0; chroma_q <= 2'd1; cyc_q <= '0;
					fonly_q <= 1'b0; w_q <= '0; h_q <= '0; err_q <= '0;
					emitted_q <= 1'b0;
				end else begin
					if (ph_q == PH_SKIP && skc_q < skip_q) skc_q <= skc_q + 4'd1;
					ph_q <= (ph_q == PH_SKIP && skc_q < skip_q) ? PH_SKIP : ph[8];
					fbc_q <= fbc[8]; gz_q <= gz[8]; gv_q <= gv[8];
					prof_q <= prof[8]; lev_q <= lev[8]; chroma_q <= chroma[8];
					cyc_q <= cyc[8]; fonly_q <= fonly[8]; w_q <= w[8]; h_q <= h[8];
					err_q <= err[8];
					if (hit) emitted_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && r_emit) res_q <= r_n;
	end

	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && !out_ch.ready |=> out_ch.valid && $stable(out_ch.res))
		else $error("result lost under stall");
	a_once: assert property (@(posedge clk) disable iff (!arst_n)
		emitted_q && take && !in_ch.last_byte |-> !r_emit)
		else $error("second result in one sps");
	a_err_dims: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid && (out_ch.res.status == ST_TRUNC || out_ch.res.status == ST_RANGE)
		|-> out_ch.res.frame_width == '0 && out_ch.res.frame_height == '0)
		else $error("dims on error result");
endmodule

/* tb/tb_avc_sps_header_parser_top.sv */
// testbench for the sps header parser: byte stream stimulus, bit-level predictor
// depends on avcsps_pkg, avcsps_if and avc_sps_header_parser_top
`timescale 1ns / 100ps

module tb_avc_sps_header_parser_top;
	import avcsps_pkg::*;

	localparam int MAXZ = 31;
	localparam int DIMB = DIM_BITS;
	localparam int LIMIT = 400000;

	logic clk, arst_n, cfg_we;
	logic [3:0] cfg_wdata;
	avcsps_in_if in_ch();
	avcsps_out_if out_ch();

	avc_sps_header_parser_top #(.MAX_GOLOMB_ZEROS(MAXZ)) DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_ch(in_ch), .out_ch(out_ch));

	// predictor state
	logic [3:0] p_skip_cfg;
	logic [5:0] p_phase;
	logic [3:0] p_skip_cnt;
	int unsigned p_bits, p_zeros, p_gval, p_prof, p_lvl, p_chroma, p_cyc, p_fonly;
	int unsigned p_w, p_h, p_err;
	bit p_emitted, p_hit;
	res_t p_res;

	res_t sps_expected[$];
	int errors = 0, n_bytes = 0, n_results = 0, cycles = 0, n_pred = 0;

	// stimulus buffer for the current sps
	logic [7:0] sbuf[$];

	function automatic bit is_high(int unsigned p);
		return p == 100 || p == 110 || p == 122 || p == 244 ||
			p == 44 || p == 83 || p == 86 || p == 118;
	endfunction

	task automatic sps_restart();
		p_phase = PH_SKIP; p_skip_cnt = 0; p_bits = 0; p_zeros = 0; p_gval = 0;
		p_prof = 0; p_lvl = 0; p_chroma = 1; p_cyc = 0; p_fonly = 0;
		p_w = 0; p_h = 0; p_err = 0; p_emitted = 0;
	endtask

	task automatic sps_emit(int unsigned st, bit dims);
		p_hit = 1;
		p_res.profile = p_prof[7:0];
		p_res.level = p_lvl[7:0];
		p_res.frame_width = dims ? p_w[15:0] : 16'd0;
		p_res.frame_height = dims ? p_h[15:0] : 16'd0;
		p_res.status = st[1:0];
		p_emitted = 1;
		p_phase = PH_DONE;
	endtask

	task automatic goto_phase(logic [5:0] ph);
		p_phase = ph; p_bits = 0; p_zeros = 0; p_gval = 0;
	endtask

	task automatic range_fail();
		p_err = ST_RANGE;
		sps_emit(ST_RANGE, 0);
	endtask

	task automatic crop(bit on_w, int unsigned v, int unsigned unit, logic [5:0] nxt);
		longint unsigned d;
		longint unsigned acc;
		d = longint'(v) * unit;
		acc = on_w ? p_w : p_h;
		if (d > acc) begin
			range_fail();
			return;
		end
		if (on_w) p_w = p_w - int'(d);
		else p_h = p_h - int'(d);
		if (nxt == PH_DONE) sps_emit(p_err, 1);
		else goto_phase(nxt);
	endtask

	task automatic golomb_done(int unsigned v);
		int unsigned dmax, cx, cy;
		dmax = (1 << DIMB) - 1;
		cx = (p_chroma == 1 || p_chroma == 2) ? 2 : 1;
		cy = (p_chroma == 1 ? 2 : 1) * (2 - p_fonly);
		case (p_phase)
			PH_SPSID: begin
				if (is_high(p_prof)) goto_phase(PH_CHROMA);
				else begin
					p_chroma = (p_prof == 183) ? 0 : 1;
					goto_phase(PH_FRAMENUM);
				end
			end
			PH_CHROMA: begin
				if (v > 3) range_fail();
				else begin
					p_chroma = v;
					goto_phase(v == 3 ? PH_SEPCOL : PH_DEPTHL);
				end
			end
			PH_DEPTHL: goto_phase(PH_DEPTHC);
			PH_DEPTHC: goto_phase(PH_BYPASS);
			PH_FRAMENUM: goto_phase(PH_POCTYPE);
			PH_POCTYPE: goto_phase(v == 0 ? PH_POCLSB : (v == 1 ? PH_DELTAZERO : PH_MAXREF));
			PH_POCLSB: goto_phase(PH_MAXREF);
			PH_OFFNONREF: goto_phase(PH_OFFTB);
			PH_OFFTB: goto_phase(PH_CYCLECNT);
			PH_CYCLECNT: begin
				if (v > 255) range_fail();
				else begin
					p_cyc = v;
					goto_phase(v == 0 ? PH_MAXREF : PH_CYCLEOFF);
				end
			end
			PH_CYCLEOFF: begin
				p_cyc = (p_cyc - 1) & 8'hff;
				goto_phase(p_cyc == 0 ? PH_MAXREF : PH_CYCLEOFF);
			end
			PH_MAXREF: goto_phase(PH_GAPS);
			PH_WIDTH: begin
				if (longint'(v) + 1 > (dmax >> 4)) range_fail();
				else begin
					p_w = (v + 1) * 16;
					goto_phase(PH_HEIGHT);
				end
			end
			PH_HEIGHT: begin
				if (longint'(v) + 1 > (dmax >> 4)) range_fail();
				else begin
					p_h = (v + 1) * 16;
					goto_phase(PH_FRAMEONLY);
				end
			end
			PH_CROPL: crop(1, v, cx, PH_CROPR);
			PH_CROPR: crop(1, v, cx, PH_CROPT);
			PH_CROPT: crop(0, v, cy, PH_CROPB);
			PH_CROPB: crop(0, v, cy, PH_DONE);
			default: goto_phase(PH_DONE);
		endcase
	endtask

	task automatic golomb_bit(bit b);
		int unsigned v;
		if (p_gval == 0) begin
			if (!b) begin
				if (p_zeros >= MAXZ) range_fail();
				else p_zeros++;
			end else if (p_zeros == 0) golomb_done(0);
			else p_gval = 1;
			return;
		end
		p_gval = (p_gval << 1) | b;
		p_zeros--;
		if (p_zeros == 0) begin
			v = p_gval - 1;
			p_gval = 0;
			golomb_done(v);
		end
	endtask

	task automatic sps_bit(bit b);
		int unsigned dmax;
		dmax = (1 << DIMB) - 1;
		case (p_phase)
			PH_PROFILE: begin
				p_prof = ((p_prof << 1) | b) & 8'hff;
				if (++p_bits == 8) goto_phase(PH_CONSTR);
			end
			PH_CONSTR: if (++p_bits == 8) goto_phase(PH_LEVEL);
			PH_LEVEL: begin
				p_lvl = ((p_lvl << 1) | b) & 8'hff;
				if (++p_bits == 8) goto_phase(PH_SPSID);
			end
			PH_SEPCOL: goto_phase(PH_DEPTHL);
			PH_BYPASS: goto_phase(PH_SCALPRES);
			PH_SCALPRES: goto_phase(b ? PH_SCALFLAGS : PH_FRAMENUM);
			PH_SCALFLAGS: begin
				if (b && p_err == 0) p_err = ST_SCAL;
				if (++p_bits == (p_chroma == 3 ? 12 : 8)) goto_phase(PH_FRAMENUM);
			end
			PH_DELTAZERO: goto_phase(PH_OFFNONREF);
			PH_GAPS: goto_phase(PH_WIDTH);
			PH_FRAMEONLY: begin
				p_fonly = b;
				if (!b && p_h > (dmax >> 1)) range_fail();
				else begin
					if (!b) p_h = p_h * 2;
					goto_phase(b ? PH_DIRECT : PH_MBAFF);
				end
			end
			PH_MBAFF: goto_phase(PH_DIRECT);
			PH_DIRECT: goto_phase(PH_CROPFLAG);
			PH_CROPFLAG: begin
				if (b) goto_phase(PH_CROPL);
				else sps_emit(p_err, 1);
			end
			PH_SKIP, PH_DONE: ;
			default: golomb_bit(b);
		endcase
	endtask

	// one accepted byte through the predictor
	task automatic sps_predict(logic [7:0] d, bit last);
		p_hit = 0;
		if (p_phase == PH_SKIP) begin
			if (p_skip_cnt < p_skip_cfg) p_skip_cnt++;
			else goto_phase(PH_PROFILE);
		end
		if (p_phase != PH_SKIP)
			for (int i = 7; i >= 0; i--)
				if (p_phase != PH_DONE) sps_bit(d[i]);
		if (last) begin
			if (!p_emitted) sps_emit(ST_TRUNC, 0);
			sps_restart();
		end
		if (p_hit) begin
			sps_expected.push_back(p_res);
			n_pred++;
		end
	endtask

	// bit writer for building sps bodies
	logic [7:0] wbyte;
	int wcnt;
	task automatic put_bits(int unsigned v, int n);
		for (int i = n - 1; i >= 0; i--) begin
			wbyte = {wbyte[6:0], 1'(v >> i)};
			if (++wcnt == 8) begin
				sbuf.push_back(wbyte);
				wcnt = 0;
			end
		end
	endtask

	task automatic put_ue(longint unsigned v);
		longint unsigned x;
		int n;
		x = v + 1;
		n = 0;
		while ((x >> n) > 1) n++;
		put_bits(0, n);
		for (int i = n; i >= 0; i--) put_bits(int'((x >> i) & 1), 1);
	endtask

	task automatic put_flush();
		if (wcnt != 0) put_bits(1, 8 - wcnt);
	endtask

	// random sps, at times with out-of-range fields, into sbuf, header bytes first, random trailing bytes last
	task automatic build_sps(int nhdr);
		int unsigned prof, cf, poc;
		int unsigned profs[10] = '{66, 77, 100, 110, 122, 244, 44, 83, 183, 88};
		sbuf.delete();
		wcnt = 0;
		wbyte = 0;
		for (int i = 0; i < nhdr; i++) sbuf.push_back($urandom_range(0, 255));
		prof = profs[$urandom_range(0, 9)];
		if ($urandom_range(0, 9) == 0) prof = $urandom_range(0, 255);
		put_bits(prof, 8);
		put_bits($urandom_range(0, 255), 8);
		put_bits($urandom_range(0, 255), 8);
		put_ue($urandom_range(0, 31));
		if (is_high(prof)) begin
			cf = ($urandom_range(0, 19) == 0) ? $urandom_range(4, 6) : $urandom_range(0, 3);
			put_ue(cf);
			if (cf == 3) put_bits($urandom_range(0, 1), 1);
			put_ue($urandom_range(0, 6));
			put_ue($urandom_range(0, 6));
			put_bits($urandom_range(0, 1), 1);
			if ($urandom_range(0, 3) == 0) begin
				put_bits(1, 1);
				for (int i = 0; i < (cf == 3 ? 12 : 8); i++)
					put_bits($urandom_range(0, 5) == 0, 1);
			end else put_bits(0, 1);
		end
		put_ue($urandom_range(0, 12));
		poc = $urandom_range(0, 3);
		put_ue(poc);
		if (poc == 0) put_ue($urandom_range(0, 12));
		else if (poc == 1) begin
			int unsigned nc;
			put_bits($urandom_range(0, 1), 1);
			put_ue($urandom_range(0, 200));
			put_ue($urandom_range(0, 200));
			nc = ($urandom_range(0, 19) == 0) ? $urandom_range(256, 300) : $urandom_range(0, 4);
			put_ue(nc);
			for (int i = 0; i < nc && i < 5; i++) put_ue($urandom_range(0, 50));
		end
		put_ue($urandom_range(0, 16));
		put_bits($urandom_range(0, 1), 1);
		put_ue(($urandom_range(0, 15) == 0) ? $urandom_range(4090, 4100) : $urandom_range(0, 120));
		put_ue(($urandom_range(0, 15) == 0) ? $urandom_range(2040, 4100) : $urandom_range(0, 70));
		put_bits($urandom_range(0, 1), 1);
		put_bits($urandom_range(0, 1), 1);
		put_bits($urandom_range(0, 1), 1);
		if ($urandom_range(0, 1)) begin
			put_bits(1, 1);
			for (int i = 0; i < 4; i++)
				put_ue(($urandom_range(0, 9) == 0) ? $urandom_range(0, 5000) : $urandom_range(0, 8));
		end else put_bits(0, 1);
		put_flush();
		for (int i = $urandom_range(0, 3); i > 0; i--) sbuf.push_back($urandom_range(0, 255));
	endtask

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("timeout at %0t", $time);
			$display("Test completed with failures");
			$finish;
		end
	end

	// result checker
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			n_results++;
			if (sps_expected.size() == 0) begin
				errors++;
				$display("%0t: unexpected result %p", $time, out_ch.res);
			end else begin
				res_t e;
				e = sps_expected.pop_front();
				if (out_ch.res.profile !== e.profile || out_ch.res.level !== e.level ||
					out_ch.res.frame_width !== e.frame_width ||
					out_ch.res.frame_height !== e.frame_height ||
					out_ch.res.status !== e.status) begin
					errors++;
					$display("%0t: mismatch expected %p actual %p", $time, e, out_ch.res);
				end
			end
		end
	end

	// receiver stalls
	initial begin
		int w;
		out_ch.ready = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 8);
			if (w > 0) begin
				out_ch.ready <= 0;
				repeat (w) @(negedge clk);
			end
			out_ch.ready <= 1;
			do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
		end
	end

	bit no_gaps;

	// valid stays high after a transfer until the next byte or an idle phase
	task automatic send_byte(logic [7:0] d, bit last);
		int w;
		w = no_gaps ? 0 : $urandom_range(0, 8);
		if (w > 0) begin
			in_ch.valid <= 0;
			repeat (w) @(negedge clk);
		end
		in_ch.valid <= 1;
		in_ch.data_byte <= d;
		in_ch.last_byte <= last;
		do @(posedge clk); while (!in_ch.ready);
		sps_predict(d, last);
		n_bytes++;
		@(negedge clk);
	endtask

	task automatic send_buf(bit with_last);
		for (int i = 0; i < sbuf.size(); i++)
			send_byte(sbuf[i], with_last && i == sbuf.size() - 1);
	endtask

	task automatic wait_idle();
		if (in_ch.valid) in_ch.valid <= 0;
		while (sps_expected.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_skip(logic [3:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 0;
		p_skip_cfg = v;
	endtask

	typedef struct {
		logic [7:0] d;
		bit last;
		bit typed;
		res_t r;
	} row_t;

	row_t dir[$];

	task automatic add_row(logic [7:0] d, bit last, bit typed, res_t r);
		row_t x;
		x.d = d; x.last = last; x.typed = typed; x.r = r;
		dir.push_back(x);
	endtask

	initial begin
		res_t none, trunc0, t1;
		logic [3:0] skips[5];
		skips = '{4'd0, 4'd15, 4'd1, 4'd5, 4'd3};
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = 0;
		in_ch.valid = 0;
		in_ch.data_byte = 0;
		in_ch.last_byte = 0;
		p_skip_cfg = SKIP_RESET;
		sps_restart();
		repeat (5) @(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// directed rows with reset skip of 5
		none = '0;
		trunc0 = '0;
		trunc0.status = ST_TRUNC;
		add_row(8'h00, 1, 1, trunc0);                    // single byte buffer
		for (int i = 0; i < 5; i++) add_row(8'hff, 0, 0, none);   // header skip
		add_row(8'hff, 0, 0, none);                      // profile 255
		add_row(8'hff, 0, 0, none);                      // constraints
		add_row(8'h00, 0, 0, none);                      // level 0
		add_row(8'h00, 0, 0, none);                      // sps id code zeros
		t1 = '0; t1.profile = 8'hff; t1.status = ST_TRUNC;
		add_row(8'hff, 1, 1, t1);
		// baseline profile 66, overlong code run
		for (int i = 0; i < 5; i++) add_row(8'h00, 0, 0, none);
		add_row(8'h42, 0, 0, none);
		add_row(8'h00, 0, 0, none);
		add_row(8'h1e, 0, 0, none);
		for (int i = 0; i < 3; i++) add_row(8'h00, 0, 0, none);
		t1 = '0; t1.profile = 8'h42; t1.level = 8'h1e; t1.status = ST_RANGE;
		add_row(8'h00, 0, 1, t1);                        // 32nd zero of the sps id code
		add_row(8'h00, 1, 0, none);
		foreach (dir[i]) begin
			int n_before;
			n_before = n_pred;
			send_byte(dir[i].d, dir[i].last);
			if (dir[i].typed && (n_pred == n_before || p_res != dir[i].r)) begin
				errors++;
				$display("%0t: directed row %0d expected %p predicted %p",
					$time, i, dir[i].r, p_res);
			end
		end
		wait_idle();

		// one full sps per skip setting in skips, bytes back to back
		no_gaps = 1;
		foreach (skips[k]) begin
			write_skip(skips[k]);
			build_sps(skips[k]);
			send_buf(1);
			wait_idle();
		end
		no_gaps = 0;

		// random part
		while (n_bytes < 1000) begin
			int kind;
			if ($urandom_range(0, 30) == 0) begin
				wait_idle();
				write_skip($urandom_range(0, 15));
			end
			kind = $urandom_range(0, 9);
			no_gaps = $urandom_range(0, 5) == 0;
			if (kind < 7) begin
				build_sps(p_skip_cfg);
				send_buf(1);
			end else if (kind < 9) begin
				build_sps(p_skip_cfg);
				while (sbuf.size() > 1 && $urandom_range(0, 2) != 0) void'(sbuf.pop_back());
				send_buf(1);
			end else begin
				sbuf.delete();
				for (int i = $urandom_range(1, 20); i > 0; i--)
					sbuf.push_back($urandom_range(0, 255));
				send_buf($urandom_range(0, 1));
			end
			if ($urandom_range(0, 40) == 0) wait_idle();
		end
		send_byte(8'h00, 1);
		no_gaps = 0;
		in_ch.valid <= 0;

		while (sps_expected.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		$display("sent %0d bytes across several skip settings, checked %0d results",
			n_bytes, n_results);
		if (errors == 0) $display("Test completed successfully");
		else $display("Test completed with failures");
		$finish;
	end
endmodule

/* filelist.f */
design/avcsps_pkg.sv
design/avcsps_if.sv
design/avcsps_bitstep.sv
design/avc_sps_header_parser_top.sv
tb/tb_avc_sps_header_parser_top.sv
